// ----- src/sapa_pkg.sv -----
`timescale 1ns / 1ps
// Package: sizes, command and status codes, and shared types of the address pool allocator.
package sapa_pkg;

  localparam int POOL_DEPTH = 256;
  localparam int OWNER_BITS = 16;

  // The used bitmap is scanned one chunk per cycle.
  localparam int CHUNK     = 16;
  localparam int CHUNK_W   = $clog2(CHUNK);
  localparam int NCH_MAX   = (POOL_DEPTH + CHUNK - 1) / CHUNK;
  localparam int CH_W      = (NCH_MAX > 1) ? $clog2(NCH_MAX) : 1;
  localparam int PAD_W     = CH_W + CHUNK_W;
  localparam int PAD_DEPTH = NCH_MAX * CHUNK;
  localparam int SIZE_W    = PAD_W + 1;
  localparam int IDX_W     = $clog2(POOL_DEPTH);
  localparam int NV_W      = CH_W + 1;

  localparam logic [1:0] CMD_INIT    = 2'd0;
  localparam logic [1:0] CMD_ACQUIRE = 2'd1;
  localparam logic [1:0] CMD_RELEASE = 2'd2;
  localparam logic [1:0] CMD_SEARCH  = 2'd3;

  localparam logic [2:0] STAT_OK         = 3'd0;
  localparam logic [2:0] STAT_EXHAUSTED  = 3'd1;
  localparam logic [2:0] STAT_OUTSIDE    = 3'd2;
  localparam logic [2:0] STAT_NOT_IN_USE = 3'd3;
  localparam logic [2:0] STAT_BAD_CLIENT = 3'd4;

  localparam logic [1:0] REG_NETWORK_BASE   = 2'd0;
  localparam logic [1:0] REG_HOST_BITS      = 2'd1;
  localparam logic [1:0] REG_SERVER_ADDRESS = 2'd2;

  localparam logic ALU_ADD = 1'b0;
  localparam logic ALU_SUB = 1'b1;

  typedef struct packed {
    logic [31:0] sum;
    logic        in_range;
  } alu_res_t;

  typedef struct packed {
    logic             found;
    logic [PAD_W-1:0] slot;
  } scan_res_t;

  // Number of pool slots: 2^host_bits, host_bits of zero taken as one, capped at the depth.
  function automatic logic [SIZE_W-1:0] pool_size(input logic [3:0] hb);
    logic [3:0]  hb_eff;
    logic [16:0] p;
    hb_eff = (hb == 4'd0) ? 4'd1 : hb;
    p = 17'd1 << hb_eff;
    if (p > 17'(POOL_DEPTH)) begin
      p = 17'(POOL_DEPTH);
    end
    return SIZE_W'(p);
  endfunction

endpackage

// ----- src/sapa_if.sv -----
`timescale 1ns / 1ps
// Interfaces: request, response and register write channels of the address pool allocator.
interface sapa_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] client_id;
  logic [31:0] address;
  modport source (output valid, cmd, client_id, address, input ready);
  modport sink (input valid, cmd, client_id, address, output ready);
endinterface

interface sapa_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] assigned_address;
  logic [15:0] owner_id;
  modport source (output valid, status, assigned_address, owner_id, input ready);
  modport sink (input valid, status, assigned_address, owner_id, output ready);
endinterface

interface sapa_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- src/sapa_alu.sv -----
`timescale 1ns / 1ps
// Shared 32-bit adder/subtractor with a subnet range check against the pool size.
module sapa_alu import sapa_pkg::*; (
  input  logic              op,
  input  logic [31:0]       a,
  input  logic [31:0]       b,
  input  logic [SIZE_W-1:0] size,
  output alu_res_t          res
);

  always_comb begin
    res.sum      = (op == ALU_SUB) ? (a - b) : (a + b);
    res.in_range = res.sum < 32'(size);
  end

endmodule

// ----- src/sapa_scan.sv -----
`timescale 1ns / 1ps
// Free slot finder for one chunk of the used bitmap, with round-robin window limits.
module sapa_scan import sapa_pkg::*; (
  input  logic [CHUNK-1:0]  bits,
  input  logic [CH_W-1:0]   chunk,
  input  logic [SIZE_W-1:0] size,
  input  logic [SIZE_W-1:0] start,
  input  logic              first,
  input  logic              last,
  output scan_res_t         res
);

  logic [CHUNK-1:0] ok;

  // On the first visit only slots at or past the start count; on the wrap-around
  // visit of the same chunk only slots before the start count.
  always_comb begin
    for (int j = 0; j < CHUNK; j++) begin
      ok[j] = !bits[j]
              && (SIZE_W'({chunk, CHUNK_W'(j)}) < size)
              && (!first || (SIZE_W'({chunk, CHUNK_W'(j)}) >= start))
              && (!last || (SIZE_W'({chunk, CHUNK_W'(j)}) < start));
    end
  end

  always_comb begin
    res.found = |ok;
    res.slot  = {chunk, CHUNK_W'(0)};
    for (int j = CHUNK - 1; j >= 0; j--) begin
      if (ok[j]) begin
        res.slot = {chunk, CHUNK_W'(j)};
      end
    end
  end

endmodule

// ----- src/sapa_owner_ram.sv -----
`timescale 1ns / 1ps
// Owner id memory: one write port, one read port with registered read data.
module sapa_owner_ram import sapa_pkg::*; (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [IDX_W-1:0]      wr_addr,
  input  logic [OWNER_BITS-1:0] wr_data,
  input  logic                  rd_en,
  input  logic [IDX_W-1:0]      rd_addr,
  output logic [OWNER_BITS-1:0] rd_data
);

  logic [OWNER_BITS-1:0] mem [POOL_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- src/subnet_address_pool_allocator.sv -----
`timescale 1ns / 1ps
// Top level: subnet address pool allocator with a bitmap scan sequencer.
//
//   channel  direction  handshake      payload
//   req      in         valid/ready    cmd, client_id, address
//   rsp      out        valid/ready    status, assigned_address, owner_id
//   cfg      in         valid/ready    index, data (ready always high)
//
// Init, release and a search that misses pass through CALC to FINISH; a search that hits adds READ.
// Acquire runs CALC, one SCAN step per bitmap chunk visited, GRANT and FINISH; an exhausted pool
// skips GRANT, and a client id of zero goes from CALC to FINISH: at most ceil(size/16) + 1 visits.
// The acquire time is set by the free-slot scan, which reads one 16-bit chunk per cycle.
// Reset clears the used bitmap, the owner valid bits and the cursor at once; no sweep.
// A finished result waits in the output register while the next item is accepted.
module subnet_address_pool_allocator import sapa_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  sapa_req_if.sink   req,
  sapa_rsp_if.source rsp,
  sapa_cfg_if.sink   cfg
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CALC   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_GRANT  = 3'd3;
  localparam logic [2:0] S_READ   = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  logic [2:0]            state;
  logic [31:0]           network_base;
  logic [3:0]            host_bits;
  logic [31:0]           server_address;
  logic [PAD_DEPTH-1:0]  used_bits;
  logic [POOL_DEPTH-1:0] owner_valid;
  logic [IDX_W-1:0]      search_cursor;
  logic [1:0]            cmd_q;
  logic [15:0]           client_q;
  logic [31:0]           addr_q;
  logic                  owner_valid_q;
  logic [PAD_W-1:0]      slot_q;
  logic [CH_W-1:0]       chunk;
  logic [NV_W-1:0]       visit;
  logic [2:0]            res_status;
  logic [31:0]           res_addr;
  logic [15:0]           res_owner;
  logic                  out_valid;

  logic [SIZE_W-1:0]     size;
  logic [SIZE_W-1:0]     cursor_ext;
  logic [SIZE_W-1:0]     start;
  logic [NV_W-1:0]       nch;
  logic [CH_W-1:0]       start_chunk;
  logic                  accept;
  logic                  alu_op;
  logic [31:0]           alu_a;
  logic [31:0]           alu_b;
  alu_res_t              alu;
  scan_res_t             scan;
  logic [IDX_W-1:0]      calc_idx;
  logic [SIZE_W-1:0]     slot_inc;
  logic                  ram_wr_en;
  logic                  ram_rd_en;
  logic [OWNER_BITS-1:0] ram_rd_data;
  logic                  first_visit;
  logic                  last_visit;
  logic                  load_out;
  logic [PAD_DEPTH-1:0]  init_bits;

  assign size        = pool_size(host_bits);
  assign cursor_ext  = SIZE_W'(search_cursor);
  // The cursor is below the depth, so it passes the size only when the size is below it; size is a power of two.
  assign start       = (cursor_ext < size) ? cursor_ext : (cursor_ext & (size - 1'b1));
  assign nch         = NV_W'((size + SIZE_W'(CHUNK - 1)) >> CHUNK_W);
  assign start_chunk = CH_W'(start >> CHUNK_W);
  assign first_visit = (visit == '0);
  assign last_visit  = (visit == nch);
  assign calc_idx    = alu.sum[IDX_W-1:0];
  assign slot_inc    = SIZE_W'(slot_q) + 1'b1;

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign load_out  = (state == S_FINISH) && (!out_valid || rsp.ready);

  assign rsp.valid            = out_valid;

  always_comb begin
    if (state == S_GRANT) begin
      alu_op = ALU_ADD;
      alu_a  = network_base;
      alu_b  = 32'(slot_q);
    end else begin
      alu_op = ALU_SUB;
      alu_a  = (cmd_q == CMD_INIT) ? server_address : addr_q;
      alu_b  = network_base;
    end
  end

  // Bitmap after init: network slot, broadcast slot and the server slot when it is in the subnet.
  always_comb begin
    init_bits = '0;
    init_bits[0] = 1'b1;
    init_bits[PAD_W'(size - 1'b1)] = 1'b1;
    if (alu.in_range) begin
      init_bits[PAD_W'(calc_idx)] = 1'b1;
    end
  end

  sapa_alu u_alu (
    .op   (alu_op),
    .a    (alu_a),
    .b    (alu_b),
    .size (size),
    .res  (alu)
  );

  sapa_scan u_scan (
    .bits  (used_bits[{chunk, CHUNK_W'(0)} +: CHUNK]),
    .chunk (chunk),
    .size  (size),
    .start (start),
    .first (first_visit),
    .last  (last_visit),
    .res   (scan)
  );

  assign ram_wr_en = (state == S_SCAN) && scan.found;
  assign ram_rd_en = (state == S_CALC) && (cmd_q == CMD_SEARCH);

  sapa_owner_ram u_owner_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (IDX_W'(scan.slot)),
    .wr_data (OWNER_BITS'(client_q)),
    .rd_en   (ram_rd_en),
    .rd_addr (calc_idx),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      network_base   <= '0;
      host_bits      <= 4'd8;
      server_address <= '0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_NETWORK_BASE:   network_base   <= cfg.data;
        REG_HOST_BITS:      host_bits      <= cfg.data[3:0];
        REG_SERVER_ADDRESS: server_address <= cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      used_bits     <= '0;
      owner_valid   <= '0;
      search_cursor <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            cmd_q      <= req.cmd;
            client_q   <= req.client_id;
            addr_q     <= req.address;
            res_status <= STAT_OK;
            res_addr   <= '0;
            res_owner  <= '0;
            visit      <= '0;
            chunk      <= start_chunk;
            state      <= S_CALC;
          end
        end
        S_CALC: begin
          case (cmd_q)
            CMD_INIT: begin
              used_bits     <= init_bits;
              owner_valid   <= '0;
              search_cursor <= '0;
              state         <= S_FINISH;
            end
            CMD_ACQUIRE: begin
              if (client_q == '0) begin
                res_status <= STAT_BAD_CLIENT;
                state      <= S_FINISH;
              end else begin
                state <= S_SCAN;
              end
            end
            CMD_RELEASE: begin
              state <= S_FINISH;
              if (!alu.in_range) begin
                res_status <= STAT_OUTSIDE;
              end else if (!used_bits[PAD_W'(calc_idx)]) begin
                res_status <= STAT_NOT_IN_USE;
              end else begin
                used_bits[PAD_W'(calc_idx)] <= 1'b0;
                owner_valid[calc_idx]       <= 1'b0;
              end
            end
            default: begin
              if (!alu.in_range) begin
                res_status <= STAT_OUTSIDE;
                state      <= S_FINISH;
              end else if (!used_bits[PAD_W'(calc_idx)]) begin
                res_status <= STAT_NOT_IN_USE;
                state      <= S_FINISH;
              end else begin
                owner_valid_q <= owner_valid[calc_idx];
                state         <= S_READ;
              end
            end
          endcase
        end
        S_SCAN: begin
          if (scan.found) begin
            used_bits[scan.slot]           <= 1'b1;
            owner_valid[IDX_W'(scan.slot)] <= 1'b1;
            slot_q                         <= scan.slot;
            state                          <= S_GRANT;
          end else if (last_visit) begin
            res_status <= STAT_EXHAUSTED;
            state      <= S_FINISH;
          end else begin
            visit <= visit + 1'b1;
            chunk <= ({1'b0, chunk} == nch - 1'b1) ? '0 : chunk + 1'b1;
          end
        end
        S_GRANT: begin
          search_cursor <= (slot_inc == size) ? '0 : IDX_W'(slot_inc);
          res_addr      <= alu.sum;
          state         <= S_FINISH;
        end
        S_READ: begin
          res_owner <= owner_valid_q ? 16'(ram_rd_data) : 16'd0;
          state     <= S_FINISH;
        end
        S_FINISH: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      rsp.status           <= res_status;
      rsp.assigned_address <= res_addr;
      rsp.owner_id         <= res_owner;
    end
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !req.ready)
    else $error("request channel stayed ready after an item was taken");

  a_grant_is_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.assigned_address != 32'd0)) |-> (rsp.status == STAT_OK))
    else $error("address granted with a failing status");

  a_cursor_in_pool: assert property (@(posedge clk) disable iff (rst)
    32'(search_cursor) < 32'(POOL_DEPTH))
    else $error("search cursor beyond pool depth");

  a_scan_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (visit <= nch))
    else $error("bitmap scan visited more chunks than the pool has");
`endif

endmodule
